/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the console writer sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define TCW_ASSERT(lbl, ck, rn, pr, ms) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) pr) else $error(ms);

// Check that a condition is never seen at a clock edge outside reset.
`define TCW_ASSERT_NEVER(lbl, ck, rn, cond, ms) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) !(cond)) else $error(ms);

`else

`define TCW_ASSERT(lbl, ck, rn, pr, ms)
`define TCW_ASSERT_NEVER(lbl, ck, rn, cond, ms)

`endif

`endif

/* rtl/core/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Screen geometry, field widths and shared types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int SCREEN_ROWS = 25;
    localparam int SCREEN_COLS = 80;
    localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
    localparam int COPY_COUNT  = (SCREEN_ROWS - 1) * SCREEN_COLS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CUR_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(SCREEN_COLS);

    // Row of a cell index by reciprocal multiplication, exact over the screen.
    localparam int ROW_SHIFT  = CUR_W + COL_W;
    localparam int ROW_RECIP  = (2 ** ROW_SHIFT + SCREEN_COLS - 1) / SCREEN_COLS;
    localparam int ROW_PROD_W = CUR_W + $clog2(ROW_RECIP + 1);

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int POS_W  = 11;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'd10;
    localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'd8;
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'd2;

    // One write port and one read port of the screen store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // One result beat.
    typedef struct packed {
        logic [POS_W-1:0]  cursor;
        logic [CHAR_W-1:0] cell_character;
        logic [ATTR_W-1:0] cell_attribute;
        logic              scrolled;
    } result_t;

endpackage

/* rtl/core/tcw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
    input  logic                       clk,
    input  tcw_pkg::ram_req_t          req,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tcw_seq.sv */
// ----------------------------------------------------------------------------
// tcw_seq
// Operation sequencer: cursor update, store sweeps and result staging.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [tcw_pkg::OP_W-1:0]   operation,
    input  logic [tcw_pkg::CHAR_W-1:0] character,
    input  logic [tcw_pkg::POS_W-1:0]  position,
    input  logic [tcw_pkg::ATTR_W-1:0] attr,
    output tcw_pkg::ram_req_t          ram_req,
    input  logic [tcw_pkg::CELL_W-1:0] ram_rdata,
    output logic                       res_valid,
    output tcw_pkg::result_t           res,
    input  logic                       res_take
);

    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int CUR_W  = tcw_pkg::CUR_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int PROD_W = tcw_pkg::ROW_PROD_W;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_COPY,
        S_BLANK,
        S_CLEAR,
        S_MOD,
        S_READ
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          cnt_reg, cnt_next;
    logic [CUR_W-1:0]           cur_reg, cur_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [CUR_W-1:0]           rem_reg, rem_next;
    logic                       cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0]          cp_addr_reg, cp_addr_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic                       pend_reg, pend_next;
    logic [tcw_pkg::CHAR_W-1:0] res_char_reg, res_char_next;
    logic [tcw_pkg::ATTR_W-1:0] res_attr_reg, res_attr_next;
    logic                       res_scr_reg, res_scr_next;

    logic                       in_accept;
    logic [tcw_pkg::CELL_W-1:0] blank_cell;
    logic                       pos_in;
    logic [CUR_W-1:0]           pos_clamp;
    logic [CUR_W-1:0]           put_cur;
    logic [COL_W-1:0]           put_col;
    logic                       put_we;
    logic [ADDR_W-1:0]          put_waddr;
    logic [tcw_pkg::CELL_W-1:0] put_wdata;
    logic                       put_wrap;
    logic [PROD_W-1:0]          mod_prod;
    logic [CUR_W-1:0]           mod_row;
    logic [COL_W-1:0]           mod_col;

    assign blank_cell = {attr, tcw_pkg::BLANK_CHAR};
    assign pos_in     = (32'(position) < tcw_pkg::CELL_COUNT);
    assign pos_clamp  = pos_in ? CUR_W'(position) : CUR_W'(tcw_pkg::CELL_COUNT - 1);

    assign in_stall  = !((state_reg == S_IDLE) && (!pend_reg || res_take));
    assign in_accept = in_valid && !in_stall;

    // Column of the new cursor: row by reciprocal multiplication, then subtract.
    assign mod_prod = PROD_W'(rem_reg) * PROD_W'(tcw_pkg::ROW_RECIP);
    assign mod_row  = CUR_W'(mod_prod >> tcw_pkg::ROW_SHIFT);
    assign mod_col  = COL_W'(rem_reg - CUR_W'(mod_row * CUR_W'(tcw_pkg::SCREEN_COLS)));

    // Cursor move and cell write of a put.
    always_comb
    begin
        put_cur   = cur_reg;
        put_col   = col_reg;
        put_we    = 1'b0;
        put_waddr = ADDR_W'(cur_reg);
        put_wdata = blank_cell;
        if (character == tcw_pkg::NEWLINE_CHAR)
        begin
            put_cur = cur_reg - CUR_W'(col_reg) + CUR_W'(tcw_pkg::SCREEN_COLS);
            put_col = '0;
        end
        else if (character == tcw_pkg::BACKSPACE_CHAR)
        begin
            if (cur_reg != '0)
            begin
                put_cur = cur_reg - 1'b1;
                put_col = (col_reg == '0) ? COL_W'(tcw_pkg::SCREEN_COLS - 1)
                                          : col_reg - 1'b1;
            end
            put_we    = 1'b1;
            put_waddr = ADDR_W'(put_cur);
        end
        else
        begin
            put_we    = 1'b1;
            put_wdata = {attr, character};
            put_cur   = cur_reg + 1'b1;
            put_col   = (col_reg == COL_W'(tcw_pkg::SCREEN_COLS - 1)) ? '0 : col_reg + 1'b1;
        end
        put_wrap = (put_cur == CUR_W'(tcw_pkg::CELL_COUNT));
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        col_next      = col_reg;
        rem_next      = rem_reg;
        cp_valid_next = cp_valid_reg;
        cp_addr_next  = cp_addr_reg;
        rd_ok_next    = rd_ok_reg;
        pend_next     = pend_reg && !res_take;
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        res_scr_next  = res_scr_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = cnt_reg;
        ram_req.wdata = blank_cell;
        ram_req.raddr = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // Zero the store after reset.
                ram_req.we    = 1'b1;
                ram_req.wdata = '0;
                if (cnt_reg == ADDR_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_char_next = '0;
                    res_attr_next = '0;
                    res_scr_next  = 1'b0;
                    unique case (op_t'(operation))
                        OP_PUT:
                        begin
                            ram_req.we    = put_we;
                            ram_req.waddr = put_waddr;
                            ram_req.wdata = put_wdata;
                            col_next      = put_col;
                            if (put_wrap)
                            begin
                                cur_next      = CUR_W'(tcw_pkg::COPY_COUNT);
                                col_next      = '0;
                                cnt_next      = '0;
                                cp_valid_next = 1'b0;
                                state_next    = S_COPY;
                            end
                            else
                            begin
                                cur_next  = put_cur;
                                pend_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_SET:
                        begin
                            cur_next   = pos_clamp;
                            rem_next   = pos_clamp;
                            state_next = S_MOD;
                        end
                        OP_READ:
                        begin
                            ram_req.raddr = pos_in ? ADDR_W'(position) : '0;
                            rd_ok_next    = pos_in;
                            state_next    = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_COPY:
            begin
                // Read one row ahead, write back the word read last cycle.
                ram_req.raddr = cnt_reg + ADDR_W'(tcw_pkg::SCREEN_COLS);
                if (cp_valid_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = cp_addr_reg;
                    ram_req.wdata = ram_rdata;
                end
                cp_valid_next = 1'b1;
                cp_addr_next  = cnt_reg;
                if (cnt_reg == ADDR_W'(tcw_pkg::COPY_COUNT - 1))
                begin
                    cnt_next   = ADDR_W'(tcw_pkg::COPY_COUNT);
                    state_next = S_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_BLANK:
            begin
                if (cp_valid_reg)
                begin
                    // Drain the last copied word first.
                    ram_req.we    = 1'b1;
                    ram_req.waddr = cp_addr_reg;
                    ram_req.wdata = ram_rdata;
                    cp_valid_next = 1'b0;
                end
                else
                begin
                    ram_req.we = 1'b1;
                    if (cnt_reg == ADDR_W'(tcw_pkg::CELL_COUNT - 1))
                    begin
                        res_scr_next = 1'b1;
                        pend_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_CLEAR:
            begin
                ram_req.we = 1'b1;
                if (cnt_reg == ADDR_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    cur_next   = '0;
                    col_next   = '0;
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MOD:
            begin
                // Load the column of the new cursor.
                col_next   = mod_col;
                pend_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                res_char_next = rd_ok_reg ? ram_rdata[tcw_pkg::CHAR_W-1:0] : '0;
                res_attr_next = rd_ok_reg ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
                pend_next     = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            cur_reg      <= '0;
            col_reg      <= '0;
            rem_reg      <= '0;
            cp_valid_reg <= 1'b0;
            cp_addr_reg  <= '0;
            rd_ok_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            res_char_reg <= '0;
            res_attr_reg <= '0;
            res_scr_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cur_reg      <= cur_next;
            col_reg      <= col_next;
            rem_reg      <= rem_next;
            cp_valid_reg <= cp_valid_next;
            cp_addr_reg  <= cp_addr_next;
            rd_ok_reg    <= rd_ok_next;
            pend_reg     <= pend_next;
            res_char_reg <= res_char_next;
            res_attr_reg <= res_attr_next;
            res_scr_reg  <= res_scr_next;
        end
    end

    assign res_valid          = pend_reg;
    assign res.cursor         = tcw_pkg::POS_W'(cur_reg);
    assign res.cell_character = res_char_reg;
    assign res.cell_attribute = res_attr_reg;
    assign res.scrolled       = res_scr_reg;

    `TCW_ASSERT(a_cur_range, clk, rst_n, (state_reg == S_IDLE) |-> (32'(cur_reg) < tcw_pkg::CELL_COUNT), "cursor outside the screen while idle")
    `TCW_ASSERT_NEVER(a_col_range, clk, rst_n, 32'(col_reg) >= tcw_pkg::SCREEN_COLS, "column beyond the row")
    `TCW_ASSERT(a_res_hold, clk, rst_n, (pend_reg && !res_take) |=> (pend_reg && $stable(cur_reg) && $stable(res_scr_reg)), "staged result lost or changed")
    `TCW_ASSERT(a_wr_range, clk, rst_n, ram_req.we |-> (32'(ram_req.waddr) < tcw_pkg::CELL_COUNT), "store write outside the screen")
    `TCW_ASSERT(a_scroll_cursor, clk, rst_n, (pend_reg && res_scr_reg) |-> (cur_reg == CUR_W'(tcw_pkg::COPY_COUNT)), "scroll did not leave cursor at last row start")

endmodule

/* rtl/core/tcw_out_reg.sv */
// ----------------------------------------------------------------------------
// tcw_out_reg
// Output register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module tcw_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  tcw_pkg::result_t res,
    output logic             res_take,
    output logic             out_valid,
    input  logic             out_stall,
    output tcw_pkg::result_t out_data
);

    logic             valid_reg, valid_next;
    tcw_pkg::result_t data_reg;

    // Take a new beat when the slot is empty or drains this cycle.
    assign res_take   = res_valid && (!valid_reg || !out_stall);
    assign valid_next = res_take || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit
// 80x25 text console writer: screen store, cursor and four operations.
// ----------------------------------------------------------------------------
// Path: a put without scroll is staged in the sequencer result register, then
//   in the output register; read and set cursor pass S_READ or S_MOD first.
// Throughput: one put per cycle while the output does not stall; read and set
//   cursor hold the input in that state; the one-write-per-cycle store sweeps
//   hold it for a clear and a scroll (24 rows copied, last word drained, one
//   row blanked); after reset a zeroing pass over every cell stalls the input.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
    input  logic                       clk,
    input  logic                       rst_n,

    // Input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [tcw_pkg::OP_W-1:0]   operation,
    input  logic [tcw_pkg::CHAR_W-1:0] character,
    input  logic [tcw_pkg::POS_W-1:0]  position,

    // Output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [tcw_pkg::POS_W-1:0]  cursor,
    output logic [tcw_pkg::CHAR_W-1:0] cell_character,
    output logic [tcw_pkg::ATTR_W-1:0] cell_attribute,
    output logic                       scrolled,

    // Attribute register write port
    input  logic                       text_attribute_we,
    input  logic [tcw_pkg::ATTR_W-1:0] text_attribute
);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    tcw_pkg::ram_req_t          ram_req;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;
    logic                       res_valid;
    logic                       res_take;
    tcw_pkg::result_t           res;
    tcw_pkg::result_t           out_data;

    // Hold the attribute used for every character and blank written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else if (text_attribute_we)
        begin
            attr_reg <= text_attribute;
        end
    end

    // Sequencer: decode each beat, move the cursor, sweep the store.
    tcw_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .character (character),
        .position  (position),
        .attr      (attr_reg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // Screen store: one cell per character position.
    tcw_screen_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Output register parts the sequencer from the receiver.
    tcw_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign cursor         = out_data.cursor;
    assign cell_character = out_data.cell_character;
    assign cell_attribute = out_data.cell_attribute;
    assign scrolled       = out_data.scrolled;

endmodule

/* tb/tb_text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer. A shadow screen, cursor
// and attribute register predict every result beat. The stimulus starts with
// directed corner cases and continues with random put, clear, set and read
// commands under several attribute settings. The input idles and the output
// stalls at random.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // Command codes of the operation field
    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR     = 2'd0,
        OP_CLEAR_SCREEN = 2'd1,
        OP_SET_CURSOR   = 2'd2,
        OP_READ_CELL    = 2'd3
    } console_op_e;

    typedef struct packed {
        console_op_e       op;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
    } console_cmd_t;

    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int LAST_ROW     = COPY_COUNT;          // first cell of the bottom row
    localparam int TAIL_CYCLES  = 2100;                // above the clear-screen latency
    // Every beat a clear plus the longest gap and stall, four times over
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 188;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   operation = '0;
    logic [CHAR_W-1:0] character = '0;
    logic [POS_W-1:0]  position = '0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [POS_W-1:0]  cursor;
    logic [CHAR_W-1:0] cell_character;
    logic [ATTR_W-1:0] cell_attribute;
    logic              scrolled;

    logic              text_attribute_we = 1'b0;
    logic [ATTR_W-1:0] text_attribute = '0;

    text_console_writer_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .character         (character),
        .position          (position),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .cursor            (cursor),
        .cell_character    (cell_character),
        .cell_attribute    (cell_attribute),
        .scrolled          (scrolled),
        .text_attribute_we (text_attribute_we),
        .text_attribute    (text_attribute)
    );

    // ------------------------------------------------------------------------
    // Shadow console: screen cells, cursor and attribute register
    // ------------------------------------------------------------------------
    logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
    int                shadow_cursor = 0;
    logic [ATTR_W-1:0] shadow_attr = ATTR_RESET;

    console_cmd_t      pending_cmds[$];       // commands not yet presented
    result_t           expected_results[$];   // one entry per accepted beat
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                read_hint = 0;         // steers random reads toward written cells

    initial begin
        foreach (shadow_screen[i])
            shadow_screen[i] = '0;
    end

    // Cell word as the block writes it: attribute high byte, character low
    function automatic logic [CELL_W-1:0] cell_word(logic [CHAR_W-1:0] ch);
        return {shadow_attr, ch};
    endfunction

    // Apply one command to the shadow console and return the beat it causes
    function automatic result_t run_console_op(console_cmd_t cmd);
        result_t res;
        int      idx;
        res = '0;
        case (cmd.op)
            OP_PUT_CHAR: begin
                if (cmd.ch == NEWLINE_CHAR) begin
                    shadow_cursor = (shadow_cursor / SCREEN_COLS + 1) * SCREEN_COLS;
                end else if (cmd.ch == BACKSPACE_CHAR) begin
                    // backspace at the first cell stays put but still blanks it
                    if (shadow_cursor > 0)
                        shadow_cursor--;
                    shadow_screen[shadow_cursor] = cell_word(BLANK_CHAR);
                end else begin
                    shadow_screen[shadow_cursor] = cell_word(cmd.ch);
                    shadow_cursor++;
                end
                // ran off the end: shift every row up, blank the bottom row
                if (shadow_cursor >= CELL_COUNT) begin
                    for (idx = 0; idx < COPY_COUNT; idx++)
                        shadow_screen[idx] = shadow_screen[idx + SCREEN_COLS];
                    for (idx = COPY_COUNT; idx < CELL_COUNT; idx++)
                        shadow_screen[idx] = cell_word(BLANK_CHAR);
                    shadow_cursor = LAST_ROW;
                    res.scrolled = 1'b1;
                end
            end
            OP_CLEAR_SCREEN: begin
                for (idx = 0; idx < CELL_COUNT; idx++)
                    shadow_screen[idx] = cell_word(BLANK_CHAR);
                shadow_cursor = 0;
            end
            OP_SET_CURSOR: begin
                shadow_cursor = (cmd.pos < CELL_COUNT) ? int'(cmd.pos) : CELL_COUNT - 1;
            end
            default: begin
                // out-of-range reads return zero and leave the cursor alone
                if (cmd.pos < CELL_COUNT) begin
                    res.cell_character = shadow_screen[cmd.pos][CHAR_W-1:0];
                    res.cell_attribute = shadow_screen[cmd.pos][CELL_W-1:CHAR_W];
                end
            end
        endcase
        res.cursor = shadow_cursor[POS_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(console_op_e op, int ch, int pos);
        console_cmd_t cmd;
        cmd.op  = op;
        cmd.ch  = ch[CHAR_W-1:0];
        cmd.pos = pos[POS_W-1:0];
        pending_cmds.push_back(cmd);
    endtask

    // Random command mix: mostly puts, a fair share of reads and cursor moves,
    // clears kept rare since each one sweeps the whole store
    function automatic console_cmd_t random_cmd();
        console_cmd_t cmd;
        int unsigned  pick;
        cmd.ch  = CHAR_W'($urandom_range(0, 255));
        cmd.pos = POS_W'($urandom_range(0, POS_MAX));
        pick = $urandom_range(0, 199);
        if (pick < 2) begin
            cmd.op = OP_CLEAR_SCREEN;
        end else if (pick < 30) begin
            cmd.op = OP_SET_CURSOR;
            case ($urandom_range(0, 3))
                // park near the end so that following puts scroll
                0: cmd.pos = POS_W'($urandom_range(CELL_COUNT - SCREEN_COLS, CELL_COUNT - 1));
                1: cmd.pos = POS_W'($urandom_range(CELL_COUNT, POS_MAX));
                default: cmd.pos = POS_W'($urandom_range(0, CELL_COUNT - 1));
            endcase
            read_hint = (cmd.pos < CELL_COUNT) ? int'(cmd.pos) : CELL_COUNT - 1;
        end else if (pick < 80) begin
            cmd.op = OP_READ_CELL;
            case ($urandom_range(0, 3))
                0: ;  // anywhere in the field range, out of range included
                1: cmd.pos = POS_W'($urandom_range(LAST_ROW - SCREEN_COLS, CELL_COUNT - 1));
                default: cmd.pos = POS_W'((read_hint + $urandom_range(0, 40)) % CELL_COUNT);
            endcase
        end else begin
            cmd.op = OP_PUT_CHAR;
            case ($urandom_range(0, 19))
                0, 1: cmd.ch = NEWLINE_CHAR;
                2:    cmd.ch = BACKSPACE_CHAR;
                default: ;
            endcase
        end
        return cmd;
    endfunction

    // Hold off until nothing is pending, presented or expected
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // Attribute writes happen only while the block is idle
    task automatic write_attribute(logic [ATTR_W-1:0] value);
        @(posedge clk);
        text_attribute_we <= 1'b1;
        text_attribute    <= value;
        shadow_attr = value;
        @(posedge clk);
        text_attribute_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(string field_name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input driver: present one command per beat, hold it while stalled,
    // then insert the gap drawn for the next one
    // ------------------------------------------------------------------------
    console_cmd_t held_cmd;
    console_cmd_t next_cmd;
    int           gap_left = 0;
    bit           in_burst = 1'b0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            // accepted beat: advance the shadow console and log the result
            if (in_valid && !in_stall)
                expected_results.push_back(run_console_op(held_cmd));
            // the slot is free unless the current beat is stalled
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_cmds.size() != 0) begin
                    next_cmd = pending_cmds.pop_front();
                    held_cmd  <= next_cmd;
                    operation <= next_cmd.op;
                    character <= next_cmd.ch;
                    position  <= next_cmd.pos;
                    in_valid  <= 1'b1;
                    // now and then switch between back-to-back and gapped beats
                    if ($urandom_range(0, 39) == 0)
                        in_burst <= !in_burst;
                    gap_left <= in_burst ? 0 : $urandom_range(0, 9);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: compare each beat against the oldest expectation and
    // stall at random, also while no beat is present
    // ------------------------------------------------------------------------
    result_t      want_result;
    int           stall_left = 0;
    int unsigned  stall_draw;
    bit           out_burst = 1'b0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected beat, expected none, actual cursor %0d",
                             $time, cursor);
                end else begin
                    want_result = expected_results.pop_front();
                    check_field("cursor", want_result.cursor, cursor);
                    check_field("cell_character", want_result.cell_character, cell_character);
                    check_field("cell_attribute", want_result.cell_attribute, cell_attribute);
                    check_field("scrolled", want_result.scrolled, scrolled);
                end
                if ($urandom_range(0, 39) == 0)
                    out_burst <= !out_burst;
                stall_draw = out_burst ? 0 : $urandom_range(0, 9);
                out_stall  <= (stall_draw != 0);
                stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
            end else if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!out_burst && $urandom_range(0, 7) == 0) begin
                // start a stall with no beat in sight so it can catch one arriving
                stall_draw = $urandom_range(1, 9);
                out_stall  <= 1'b1;
                stall_left <= stall_draw - 1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed corners, random phases, drain and verdict
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int items_left;
        int chunk;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, default attribute. The store is zero out of reset.
        queue_cmd(OP_READ_CELL, 0, 0);
        queue_cmd(OP_READ_CELL, 0, POS_MAX);              // read out of range
        queue_cmd(OP_PUT_CHAR, 8'h41, 0);
        queue_cmd(OP_PUT_CHAR, 8'h00, 0);                 // character zero is ordinary
        queue_cmd(OP_PUT_CHAR, 8'hFF, 0);
        queue_cmd(OP_READ_CELL, 0, 2);
        queue_cmd(OP_PUT_CHAR, BACKSPACE_CHAR, 0);
        queue_cmd(OP_READ_CELL, 0, 2);
        queue_cmd(OP_SET_CURSOR, 0, 0);
        queue_cmd(OP_PUT_CHAR, BACKSPACE_CHAR, 0);        // backspace at the first cell
        queue_cmd(OP_READ_CELL, 0, 0);
        queue_cmd(OP_PUT_CHAR, NEWLINE_CHAR, 0);
        queue_cmd(OP_SET_CURSOR, 0, POS_MAX);             // clamps to the last cell
        queue_cmd(OP_PUT_CHAR, 8'h5A, 0);                 // runs off the end: scroll
        queue_cmd(OP_READ_CELL, 0, CELL_COUNT - 1);
        queue_cmd(OP_READ_CELL, 0, CELL_COUNT - 1 - SCREEN_COLS);
        queue_cmd(OP_PUT_CHAR, NEWLINE_CHAR, 0);          // newline on the bottom row
        queue_cmd(OP_SET_CURSOR, 0, CELL_COUNT - 1);
        queue_cmd(OP_PUT_CHAR, BACKSPACE_CHAR, 0);
        queue_cmd(OP_PUT_CHAR, 8'h7E, 0);
        queue_cmd(OP_CLEAR_SCREEN, 0, 0);
        queue_cmd(OP_READ_CELL, 0, 0);
        queue_cmd(OP_SET_CURSOR, 0, CELL_COUNT);          // first position out of range
        queue_cmd(OP_READ_CELL, 0, CELL_COUNT - 1);
        wait_until_drained();

        // Random phases, each under its own attribute setting
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: write_attribute(8'hFF);
                1: write_attribute(8'h00);
                default: write_attribute(ATTR_W'($urandom_range(0, 255)));
            endcase
            items_left = PHASE_ITEMS;
            while (items_left > 0) begin
                chunk = $urandom_range(10, 60);
                if (chunk > items_left)
                    chunk = items_left;
                repeat (chunk)
                    pending_cmds.push_back(random_cmd());
                items_left -= chunk;
                // pause the sender completely now and then, else top up
                if ($urandom_range(0, 3) == 0)
                    wait_until_drained();
                else
                    do
                        @(negedge clk);
                    while (pending_cmds.size() > 2);
            end
            wait_until_drained();
        end

        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_screen_ram.sv
rtl/core/tcw_seq.sv
rtl/core/tcw_out_reg.sv
rtl/core/text_console_writer_unit.sv
tb/tb_text_console_writer_unit.sv
